// File: hdl/slt_pkg.sv
// shared constants, types and the sine table of the sprite line transform
`timescale 1ns / 1ps
`default_nettype none

package slt_pkg;

  localparam int SPRITE_SLOTS     = 16;
  localparam int LINES_PER_SPRITE = 10;
  localparam int SCREEN_WIDTH     = 1024;
  localparam int SCREEN_HEIGHT    = 768;

  localparam int ENDS_PER_SPRITE = 2 * LINES_PER_SPRITE;
  localparam int POINT_DEPTH     = SPRITE_SLOTS * ENDS_PER_SPRITE;
  localparam int ADDR_W          = $clog2(POINT_DEPTH);
  localparam int SLOT_W          = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;
  localparam int CNT_W           = $clog2(LINES_PER_SPRITE + 1);
  localparam int LIDX_W          = (LINES_PER_SPRITE > 1) ? $clog2(LINES_PER_SPRITE) : 1;

  // request field widths
  localparam int CMD_W   = 2;
  localparam int SEL_W   = 4;
  localparam int IDX_W   = 5;
  localparam int COORD_W = 8;
  localparam int TOTAL_W = 4;
  localparam int ANGLE_W = 10;
  localparam int SCALE_W = 16;
  localparam int DISP_W  = 16;
  localparam int POINT_W = 2 * COORD_W;
  localparam int TRIG_W  = 16;

  localparam int IN_FIELDS_W  = SEL_W + IDX_W + 2 * COORD_W + TOTAL_W + ANGLE_W
                                + SCALE_W + 2 * DISP_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_W        = 13;
  localparam int OUT_FIELDS_W = 4 * OUT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // datapath widths
  localparam int ROT_W     = COORD_W + TRIG_W + 1;
  localparam int PROD_W    = ROT_W + SCALE_W + 1;
  localparam int SUM_W     = PROD_W + 1;
  localparam int FRAC_W    = 22;
  localparam int SHIFT_POS = 18;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_POINT = 2'd0,
    CMD_WR_COUNT = 2'd1,
    CMD_DRAW     = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]        base;
    logic [CNT_W-1:0]         lines;
    logic signed [TRIG_W-1:0] sin_q;
    logic signed [TRIG_W-1:0] cos_q;
    logic [SCALE_W-1:0]       scale;
    logic signed [DISP_W-1:0] dx;
    logic signed [DISP_W-1:0] dy;
  } draw_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // quarter wave of round(16384*sin), worked out at elaboration
  typedef logic [14:0] qsine_tab_t [257];

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic qsine_tab_t build_qsine();
    qsine_tab_t   tab;
    logic [63:0]  step;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  den;
    logic [127:0] prod;
    step = 64'h3243F6A8885A308D >> 9;
    for (int k = 0; k <= 256; k++) begin
      x    = step * 64'(k);
      prod = {64'b0, x} * {64'b0, x};
      x2   = prod[123:60];
      term = x;
      sum  = x;
      for (int n = 1; n < 40; n++) begin
        if (term != 64'd0) begin
          prod = {64'b0, term} * {64'b0, x2};
          den  = 64'((2 * n) * (2 * n + 1));
          term = udiv64(prod[123:60], den);
          if (n[0]) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
      tab[k] = 15'((sum + (64'd1 << 45)) >> 46);
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE = build_qsine();

  function automatic logic signed [TRIG_W-1:0] sine_at(input logic [ANGLE_W-1:0] k);
    logic [8:0]  ridx;
    logic [14:0] mag;
    ridx = k[8] ? (9'd256 - {1'b0, k[7:0]}) : {1'b0, k[7:0]};
    mag  = QSINE[ridx];
    return k[9] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

`default_nettype wire

// File: hdl/slt_ram.sv
// generic single write, single read memory with registered read data
`timescale 1ns / 1ps
`default_nettype none

module slt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 320
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/slt_front.sv
// front end: takes requests, performs writes, turns draws into queue entries
`timescale 1ns / 1ps
`default_nettype none

module slt_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [slt_pkg::IN_DATA_W-1:0]  in_data,
  input  wire logic [slt_pkg::CMD_W-1:0]      in_user,
  input  wire slt_pkg::q_stat_t               q_stat,
  input  wire logic                           back_idle,
  output logic                                push,
  output slt_pkg::draw_req_t                  push_req,
  output logic                                ram_we,
  output logic [slt_pkg::ADDR_W-1:0]          ram_waddr,
  output logic [slt_pkg::POINT_W-1:0]         ram_wdata
);

  localparam int OFF_SEL   = 0;
  localparam int OFF_IDX   = OFF_SEL + slt_pkg::SEL_W;
  localparam int OFF_X     = OFF_IDX + slt_pkg::IDX_W;
  localparam int OFF_Y     = OFF_X + slt_pkg::COORD_W;
  localparam int OFF_TOTAL = OFF_Y + slt_pkg::COORD_W;
  localparam int OFF_ANGLE = OFF_TOTAL + slt_pkg::TOTAL_W;
  localparam int OFF_SCALE = OFF_ANGLE + slt_pkg::ANGLE_W;
  localparam int OFF_DX    = OFF_SCALE + slt_pkg::SCALE_W;
  localparam int OFF_DY    = OFF_DX + slt_pkg::DISP_W;

  slt_pkg::cmd_t                  cmd;
  logic [slt_pkg::SEL_W-1:0]      sel;
  logic [slt_pkg::IDX_W-1:0]      idx;
  logic [slt_pkg::COORD_W-1:0]    cx;
  logic [slt_pkg::COORD_W-1:0]    cy;
  logic [slt_pkg::TOTAL_W-1:0]    total;
  logic [slt_pkg::ANGLE_W-1:0]    angle;
  logic [slt_pkg::SCALE_W-1:0]    scale;
  logic [slt_pkg::DISP_W-1:0]     dx;
  logic [slt_pkg::DISP_W-1:0]     dy;
  logic                           slot_ok;
  logic                           idx_ok;
  logic                           accept;
  logic [slt_pkg::CNT_W-1:0]      cnt_sat;
  logic [slt_pkg::CNT_W-1:0]      cur_cnt;
  logic [slt_pkg::ADDR_W-1:0]     base;

  // per-sprite line counts
  logic [slt_pkg::CNT_W-1:0] cnt_store [slt_pkg::SPRITE_SLOTS];

  always_comb begin
    cmd   = slt_pkg::cmd_t'(in_user);
    sel   = in_data[OFF_SEL +: slt_pkg::SEL_W];
    idx   = in_data[OFF_IDX +: slt_pkg::IDX_W];
    cx    = in_data[OFF_X +: slt_pkg::COORD_W];
    cy    = in_data[OFF_Y +: slt_pkg::COORD_W];
    total = in_data[OFF_TOTAL +: slt_pkg::TOTAL_W];
    angle = in_data[OFF_ANGLE +: slt_pkg::ANGLE_W];
    scale = in_data[OFF_SCALE +: slt_pkg::SCALE_W];
    dx    = in_data[OFF_DX +: slt_pkg::DISP_W];
    dy    = in_data[OFF_DY +: slt_pkg::DISP_W];
  end

  assign slot_ok = int'(sel) < slt_pkg::SPRITE_SLOTS;
  assign idx_ok  = int'(idx) < slt_pkg::ENDS_PER_SPRITE;
  assign cnt_sat = (int'(total) > slt_pkg::LINES_PER_SPRITE)
                   ? slt_pkg::CNT_W'(slt_pkg::LINES_PER_SPRITE)
                   : slt_pkg::CNT_W'(total);
  assign cur_cnt = cnt_store[sel[slt_pkg::SLOT_W-1:0]];
  assign base    = slt_pkg::ADDR_W'(sel) * slt_pkg::ADDR_W'(slt_pkg::ENDS_PER_SPRITE);

  // endpoint writes wait until every queued draw has read the store
  always_comb begin
    unique case (cmd)
      slt_pkg::CMD_WR_POINT: in_ready = back_idle && q_stat.empty;
      slt_pkg::CMD_DRAW:     in_ready = !q_stat.full;
      default:               in_ready = 1'b1;
    endcase
  end

  assign accept = in_valid && in_ready;

  assign ram_we    = accept && (cmd == slt_pkg::CMD_WR_POINT) && slot_ok && idx_ok;
  assign ram_waddr = base + slt_pkg::ADDR_W'(idx);
  assign ram_wdata = {cx, cy};

  assign push = accept && (cmd == slt_pkg::CMD_DRAW) && slot_ok && (cur_cnt != '0);

  always_comb begin
    push_req.base  = base;
    push_req.lines = cur_cnt;
    push_req.sin_q = slt_pkg::sine_at(angle);
    push_req.cos_q = slt_pkg::sine_at(angle + slt_pkg::ANGLE_W'(256));
    push_req.scale = scale;
    push_req.dx    = $signed(dx);
    push_req.dy    = $signed(dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < slt_pkg::SPRITE_SLOTS; i++) begin
        cnt_store[i] <= '0;
      end
    end else if (accept && (cmd == slt_pkg::CMD_WR_COUNT) && slot_ok) begin
      cnt_store[sel[slt_pkg::SLOT_W-1:0]] <= cnt_sat;
    end
  end

endmodule

`default_nettype wire

// File: hdl/slt_queue.sv
// short draw queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none

module slt_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire slt_pkg::draw_req_t push_req,
  input  wire logic               pop,
  output slt_pkg::draw_req_t      pop_req,
  output slt_pkg::q_stat_t        stat
);

  slt_pkg::draw_req_t            entries [slt_pkg::QUEUE_DEPTH];
  logic [slt_pkg::QPTR_W-1:0]    wr_ptr;
  logic [slt_pkg::QPTR_W-1:0]    rd_ptr;
  logic [slt_pkg::QCNT_W-1:0]    count;

  function automatic logic [slt_pkg::QPTR_W-1:0] wrap_inc(input logic [slt_pkg::QPTR_W-1:0] p);
    return (int'(p) == slt_pkg::QUEUE_DEPTH - 1) ? '0 : p + slt_pkg::QPTR_W'(1);
  endfunction

  assign pop_req    = entries[rd_ptr];
  assign stat.full  = count == slt_pkg::QCNT_W'(slt_pkg::QUEUE_DEPTH);
  assign stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + slt_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - slt_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

endmodule

`default_nettype wire

// File: hdl/slt_back.sv
// back end: walks a sprite's endpoints and transforms them onto the screen
`timescale 1ns / 1ps
`default_nettype none

module slt_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire slt_pkg::q_stat_t             q_stat,
  input  wire slt_pkg::draw_req_t           req,
  output logic                              pop,
  output logic                              back_idle,
  output logic                              ram_re,
  output logic [slt_pkg::ADDR_W-1:0]        ram_raddr,
  input  wire logic [slt_pkg::POINT_W-1:0]  ram_rdata,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [slt_pkg::OUT_W-1:0]         start_x,
  output logic [slt_pkg::OUT_W-1:0]         start_y,
  output logic [slt_pkg::OUT_W-1:0]         end_x,
  output logic [slt_pkg::OUT_W-1:0]         end_y,
  output logic                              last_line
);

  localparam int QW      = slt_pkg::SUM_W - slt_pkg::FRAC_W;
  localparam int PL_W    = QW + 1;
  localparam int OUT_MAX = 2 ** (slt_pkg::OUT_W - 1) - 1;
  localparam int OUT_MIN = -(2 ** (slt_pkg::OUT_W - 1));
  localparam int HALF_X  = slt_pkg::SCREEN_WIDTH / 2;
  localparam int HALF_Y  = slt_pkg::SCREEN_HEIGHT / 2;

  slt_pkg::draw_req_t              cur;
  logic                            active;
  logic [slt_pkg::LIDX_W-1:0]      line_idx;
  logic                            end_sel;
  logic                            adv;
  logic                            issue;
  logic                            is_last;

  logic                            b_v, b_end, b_last;
  logic                            c_v, c_end, c_last;
  logic                            d_v, d_end, d_last;
  logic                            e_v, e_end, e_last;

  logic signed [slt_pkg::COORD_W-1:0] px_in;
  logic signed [slt_pkg::COORD_W-1:0] py_in;
  logic signed [slt_pkg::ROT_W-1:0]   rot_x, rot_y, c_rx, c_ry;
  logic signed [slt_pkg::SCALE_W:0]   scale_s;
  logic signed [slt_pkg::PROD_W-1:0]  scl_x, scl_y, d_px, d_py;
  logic signed [slt_pkg::SUM_W-1:0]   sum_x, sum_y, e_sx, e_sy;
  logic [slt_pkg::OUT_W-1:0]          pl_x, pl_y;
  logic [slt_pkg::OUT_W-1:0]          hold_x, hold_y;

  // truncate toward zero, centre and saturate
  function automatic logic [slt_pkg::OUT_W-1:0] place(
    input logic signed [slt_pkg::SUM_W-1:0] s,
    input int                               half
  );
    logic signed [QW-1:0]   q;
    logic                   corr;
    logic signed [PL_W-1:0] v;
    logic [slt_pkg::OUT_W-1:0] r;
    q    = $signed(s[slt_pkg::SUM_W-1:slt_pkg::FRAC_W]);
    corr = s[slt_pkg::SUM_W-1] && (s[slt_pkg::FRAC_W-1:0] != '0);
    v    = PL_W'(q) + (corr ? PL_W'(half + 1) : PL_W'(half));
    if (v > PL_W'(OUT_MAX)) begin
      r = slt_pkg::OUT_W'(OUT_MAX);
    end else if (v < PL_W'(OUT_MIN)) begin
      r = slt_pkg::OUT_W'(OUT_MIN);
    end else begin
      r = v[slt_pkg::OUT_W-1:0];
    end
    return r;
  endfunction

  assign adv       = !out_valid || out_ready;
  assign back_idle = !active && !b_v && !c_v && !d_v && !e_v;
  assign pop       = back_idle && !q_stat.empty;
  assign issue     = active && adv;
  assign is_last   = slt_pkg::CNT_W'(line_idx) == (cur.lines - slt_pkg::CNT_W'(1));

  assign ram_re    = issue;
  assign ram_raddr = cur.base + slt_pkg::ADDR_W'({line_idx, end_sel});

  // rotation on the endpoint read from the store
  assign px_in = $signed(ram_rdata[slt_pkg::POINT_W-1:slt_pkg::COORD_W]);
  assign py_in = $signed(ram_rdata[slt_pkg::COORD_W-1:0]);
  assign rot_x = slt_pkg::ROT_W'(px_in) * slt_pkg::ROT_W'(cur.cos_q)
               - slt_pkg::ROT_W'(py_in) * slt_pkg::ROT_W'(cur.sin_q);
  assign rot_y = slt_pkg::ROT_W'(py_in) * slt_pkg::ROT_W'(cur.cos_q)
               + slt_pkg::ROT_W'(px_in) * slt_pkg::ROT_W'(cur.sin_q);

  // scale
  assign scale_s = $signed({1'b0, cur.scale});
  assign scl_x   = c_rx * scale_s;
  assign scl_y   = c_ry * scale_s;

  // displacement in the same binary point
  assign sum_x = slt_pkg::SUM_W'(d_px) + (slt_pkg::SUM_W'(cur.dx) <<< slt_pkg::SHIFT_POS);
  assign sum_y = slt_pkg::SUM_W'(d_py) + (slt_pkg::SUM_W'(cur.dy) <<< slt_pkg::SHIFT_POS);

  assign pl_x = place(e_sx, HALF_X);
  assign pl_y = place(e_sy, HALF_Y);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      line_idx  <= '0;
      end_sel   <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      d_v       <= 1'b0;
      e_v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active   <= 1'b1;
        line_idx <= '0;
        end_sel  <= 1'b0;
      end else if (issue) begin
        end_sel <= ~end_sel;
        if (end_sel) begin
          if (is_last) begin
            active <= 1'b0;
          end else begin
            line_idx <= line_idx + slt_pkg::LIDX_W'(1);
          end
        end
      end
      if (adv) begin
        b_v       <= issue;
        c_v       <= b_v;
        d_v       <= c_v;
        e_v       <= d_v;
        out_valid <= e_v && e_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= req;
    end
    if (adv) begin
      b_end  <= end_sel;
      b_last <= is_last;
      c_end  <= b_end;
      c_last <= b_last;
      c_rx   <= rot_x;
      c_ry   <= rot_y;
      d_end  <= c_end;
      d_last <= c_last;
      d_px   <= scl_x;
      d_py   <= scl_y;
      e_end  <= d_end;
      e_last <= d_last;
      e_sx   <= sum_x;
      e_sy   <= sum_y;
      if (e_v && !e_end) begin
        hold_x <= pl_x;
        hold_y <= pl_y;
      end
      if (e_v && e_end) begin
        start_x   <= hold_x;
        start_y   <= hold_y;
        end_x     <= pl_x;
        end_y     <= pl_y;
        last_line <= e_last;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/sprite_line_transform.sv
// top level of the sprite line transform
`timescale 1ns / 1ps
`default_nettype none

// channel     dir  handshake                      payload
// request     in   s_axis_tvalid / s_axis_tready  s_axis_tdata, s_axis_tuser (command)
// line        out  m_axis_tvalid / m_axis_tready  m_axis_tdata, m_axis_tlast (last line)
//
// a count write is never held off; a point write waits until drawing has finished and the queue is empty
// a draw is queued, then popped once the back end is idle, and its endpoints are read from the point store
// one endpoint read a cycle while the line output is not stalled; a line goes out once both its endpoints are placed
// the next draw starts once the back end has drained; up to two draws wait in the queue
// reset is synchronous and clears line counts at once; the point store is not cleared
// a stalled line output stalls the whole back-end pipeline, the front end goes on

module sprite_line_transform (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sprite_sel, endpoint_index, coord_x, coord_y, line_total, angle,
  // scale_factor, shift_x, shift_y, zero pad
  input  wire logic [slt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // cmd
  input  wire logic [slt_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // start_x, start_y, end_x, end_y, zero pad
  output logic [slt_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output logic                                 m_axis_tlast
);

  slt_pkg::q_stat_t                q_stat;
  slt_pkg::draw_req_t              push_req;
  slt_pkg::draw_req_t              pop_req;
  logic                            push;
  logic                            pop;
  logic                            back_idle;
  logic                            ram_we;
  logic [slt_pkg::ADDR_W-1:0]      ram_waddr;
  logic [slt_pkg::POINT_W-1:0]     ram_wdata;
  logic                            ram_re;
  logic [slt_pkg::ADDR_W-1:0]      ram_raddr;
  logic [slt_pkg::POINT_W-1:0]     ram_rdata;
  logic [slt_pkg::OUT_W-1:0]       start_x, start_y, end_x, end_y;

  // decode, writes and draw set-up
  slt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .q_stat    (q_stat),
    .back_idle (back_idle),
    .push      (push),
    .push_req  (push_req),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  // draws waiting for the back end
  slt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .pop_req  (pop_req),
    .stat     (q_stat)
  );

  // endpoint store, x in the upper byte
  slt_ram #(
    .WIDTH (slt_pkg::POINT_W),
    .DEPTH (slt_pkg::POINT_DEPTH)
  ) u_points (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // rotate, scale, displace and place, one endpoint a cycle while the line output is not stalled
  slt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .req       (pop_req),
    .pop       (pop),
    .back_idle (back_idle),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .last_line (m_axis_tlast)
  );

  assign m_axis_tdata = {(slt_pkg::OUT_DATA_W - slt_pkg::OUT_FIELDS_W)'(0),
                         end_y, end_x, start_y, start_x};

endmodule

`default_nettype wire

// File: hdl/slt_chk.sv
// port checker for the sprite line transform and its bind
`timescale 1ns / 1ps
`default_nettype none

module slt_chk (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [slt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input wire logic [slt_pkg::CMD_W-1:0]       s_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [slt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input wire logic                            m_axis_tlast
);

  // output register empties on reset
  a_reset_clears : assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("line output valid after reset");

  // a request that is held off stays on offer unchanged
  a_request_holds : assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("waiting request changed");

  // a stalled line keeps its contents
  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled line changed");

  // padding above the coordinates stays zero
  a_pad_zero : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      m_axis_tdata[slt_pkg::OUT_DATA_W-1:slt_pkg::OUT_FIELDS_W] == '0)
    else $error("line padding not zero");

  // no line appears within the pipeline depth after reset
  a_min_latency : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3)
                      && !$past(rst, 4) && !$past(rst, 5))
    else $error("line appeared too soon after reset");

endmodule

bind sprite_line_transform slt_chk u_slt_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
